// ===== hw/rtl/multi_timer_event_table_assert.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef MULTI_TIMER_EVENT_TABLE_ASSERT_SVH
`define MULTI_TIMER_EVENT_TABLE_ASSERT_SVH
// Concurrent assertion clocked on rising clk, off during reset.
`define MTET_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

// ===== hw/rtl/mtet_pkg.sv =====
// Types and constants of the timer pool.
// Depends on nothing.
package mtet_pkg;
	localparam int TimerSlotsDefault = 8;
	localparam int RemW = 29;

	typedef enum logic [1:0] {
		CMD_REQUEST = 2'd0,
		CMD_CANCEL  = 2'd1,
		CMD_TICK    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	localparam logic [1:0] RK_STATUS = 2'd0;
	localparam logic [1:0] RK_EXPIRY = 2'd1;
	localparam logic [1:0] RK_TICK   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [7:0]        message_id;
		logic [7:0]        event_kind;
		logic signed [7:0] receiver_id;
		logic [31:0]       delay_ms;
		logic [31:0]       elapsed_ticks;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [1:0]        status;
		logic signed [7:0] out_receiver;
		logic [7:0]        out_kind;
		logic [7:0]        out_message;
		logic [32:0]       shortest_ms;
		logic [31:0]       runtime_ticks;
		logic              last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture input item, clear walk and minimum
		logic insert;   // request: put new timer at head
		logic walk;     // read-only pass: track minimum of surviving slots
		logic rewind;   // clear scan index, write pointer and match flag
		logic scan;     // process slot at scan index
		logic finish;   // commit compacted list
		logic emit_rec; // load output from current slot
		logic emit_end; // load final output
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic expire;   // slot at scan index expires / matches
		cmd_t cmd;
	} dp_sts_t;

	// ms to ticks: above 20 gives ms/10+1, else 2
	function automatic logic [RemW-1:0] ms_to_ticks(input logic [31:0] ms);
		logic [63:0] prod;
		begin
			// floor(ms / 10) by reciprocal multiplication, exact over 32 bits
			prod = 64'(ms) * 64'(32'hCCCC_CCCD);
			ms_to_ticks = (ms > 32'd20) ? prod[63:35] + RemW'(1) : RemW'(2);
		end
	endfunction
endpackage

// ===== hw/rtl/multi_timer_event_table.sv =====
// Timer pool: request, cancel and tick handling, result per step.
// Request and unknown code: decode, a walk over the live slots for the minimum,
// then the final result; cancel and tick: a second walk compacts the list, a
// tick also emitting one expiry per expired slot, before the final result.
// Next input is taken only after the final result has been taken.
// Reset (arst_n low) empties the pool and clears the runtime counter.
module multi_timer_event_table #(
	parameter int TIMER_SLOTS = mtet_pkg::TimerSlotsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mtet_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mtet_pkg::out_item_t out_data
);
	import mtet_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequence the walk; hold the output until taken
	mtet_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.cmd, .sts
	);

	// slots, compaction and the output register
	mtet_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
		.clk, .arst_n, .in_item(in_data), .out_item(out_data), .cmd, .sts
	);
endmodule

// ===== hw/rtl/mtet_ctrl.sv =====
// Sequencer of the timer pool: handshakes and walk over the slots.
// Depends on mtet_pkg.
module mtet_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output mtet_pkg::dp_cmd_t cmd,
	input  mtet_pkg::dp_sts_t sts
);
	import mtet_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DEC  = 6'b000010,
		S_PRE  = 6'b000100,
		S_SCAN = 6'b001000,
		S_OUT  = 6'b010000,
		S_END  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   ovalid_q, ovalid_d;

	assign in_ready  = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;

	always_comb begin
		state_d  = state_q;
		ovalid_d = ovalid_q && !out_ready;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.cmd == CMD_REQUEST) cmd.insert = 1'b1;
				state_d = S_PRE;
			end
			S_PRE: begin
				if (sts.scan_done) begin
					if (sts.cmd == CMD_CANCEL || sts.cmd == CMD_TICK) begin
						cmd.rewind = 1'b1;
						state_d    = S_SCAN;
					end else begin
						state_d = S_END;
					end
				end else begin
					cmd.walk = 1'b1;
				end
			end
			S_SCAN: begin
				if (!ovalid_d) begin
					if (sts.scan_done) begin
						cmd.finish = 1'b1;
						state_d    = S_END;
					end else begin
						cmd.scan = 1'b1;
						if (sts.expire && sts.cmd == CMD_TICK) begin
							cmd.emit_rec = 1'b1;
							ovalid_d     = 1'b1;
						end
					end
				end
			end
			S_END: begin
				if (!ovalid_d) begin
					cmd.emit_end = 1'b1;
					ovalid_d     = 1'b1;
					state_d      = S_OUT;
				end
			end
			S_OUT: begin
				if (!ovalid_d) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ovalid_q <= ovalid_d;
		end
	end
endmodule

// ===== hw/rtl/mtet_dp.sv =====
// Slot store, scan compaction, minimum search and output register.
// Depends on mtet_pkg.
module mtet_dp #(
	parameter int TIMER_SLOTS = mtet_pkg::TimerSlotsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mtet_pkg::in_item_t  in_item,
	output mtet_pkg::out_item_t out_item,
	input  mtet_pkg::dp_cmd_t   cmd,
	output mtet_pkg::dp_sts_t   sts
);
	import mtet_pkg::*;

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);

	in_item_t        item_q;
	logic [7:0]      msg_q [TIMER_SLOTS];
	logic [7:0]      kind_q[TIMER_SLOTS];
	logic [7:0]      recv_q[TIMER_SLOTS];
	logic [RemW-1:0] rem_q [TIMER_SLOTS];
	logic [CW-1:0]   used_q, rd_q, wr_q;
	logic            found_q;
	logic            full_q;
	logic [31:0]     rt_q;
	logic [RemW-1:0] min_q;
	logic            minv_q;
	out_item_t       out_q;

	logic [IW-1:0]   ri, wi;
	logic            is_tick, is_cancel;
	logic            hit;
	logic [RemW-1:0] cur_rem;
	logic [RemW-1:0] new_rem;
	logic            keep;
	logic [RemW-1:0] ins_rem;
	logic [32:0]     sh;
	out_item_t       rec_d, end_d;

	assign ri        = rd_q[IW-1:0];
	assign wi        = wr_q[IW-1:0];
	assign cur_rem   = rem_q[ri];
	assign is_tick   = (cmd_t'(item_q.command) == CMD_TICK);
	assign is_cancel = (cmd_t'(item_q.command) == CMD_CANCEL);
	// remaining is 29 bits, so compare in 32; requests and unused codes keep all
	assign hit = is_tick
		? ({3'b0, cur_rem} <= item_q.elapsed_ticks)
		: (is_cancel && !found_q && recv_q[ri] == item_q.receiver_id
			&& msg_q[ri] == item_q.message_id);
	assign new_rem = is_tick ? cur_rem - item_q.elapsed_ticks[RemW-1:0] : cur_rem;
	assign keep    = !hit;
	assign ins_rem = ms_to_ticks(item_q.delay_ms);
	// times 10 as 8x + 2x
	assign sh = minv_q ? ({1'b0, min_q, 3'b000} + {3'b000, min_q, 1'b0}) : 33'd0;

	assign sts.scan_done = (rd_q == used_q);
	assign sts.expire    = hit;
	assign sts.cmd       = cmd_t'(item_q.command);
	assign out_item      = out_q;

	always_comb begin
		rec_d               = '0;
		rec_d.result_kind   = RK_EXPIRY;
		rec_d.out_receiver  = recv_q[ri];
		rec_d.out_kind      = kind_q[ri];
		rec_d.out_message   = msg_q[ri];
		rec_d.shortest_ms   = sh;
		rec_d.runtime_ticks = rt_q;
		end_d               = '0;
		end_d.last          = 1'b1;
		end_d.shortest_ms   = sh;
		end_d.runtime_ticks = rt_q;
		case (cmd_t'(item_q.command))
			CMD_REQUEST: end_d.status = full_q ? ST_FULL : ST_OK;
			CMD_CANCEL:  end_d.status = found_q ? ST_OK : ST_NOMATCH;
			CMD_TICK:    end_d.result_kind = RK_TICK;
			default:     end_d.status = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.insert && used_q != CW'(TIMER_SLOTS)) begin
			for (int i = TIMER_SLOTS - 1; i > 0; i--) begin
				msg_q[i]  <= msg_q[i-1];
				kind_q[i] <= kind_q[i-1];
				recv_q[i] <= recv_q[i-1];
				rem_q[i]  <= rem_q[i-1];
			end
			msg_q[0]  <= item_q.message_id;
			kind_q[0] <= item_q.event_kind;
			recv_q[0] <= item_q.receiver_id;
			rem_q[0]  <= ins_rem;
		end
		if (cmd.scan && keep) begin
			msg_q[wi]  <= msg_q[ri];
			kind_q[wi] <= kind_q[ri];
			recv_q[wi] <= recv_q[ri];
			rem_q[wi]  <= new_rem;
		end
		if (cmd.emit_rec) out_q <= rec_d;
		else if (cmd.emit_end) out_q <= end_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			found_q <= 1'b0;
			rt_q    <= '0;
			min_q   <= '0;
			minv_q  <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_q    <= '0;
				wr_q    <= '0;
				found_q <= 1'b0;
				minv_q  <= 1'b0;
				if (cmd_t'(in_item.command) == CMD_TICK)
					rt_q <= rt_q + in_item.elapsed_ticks;
			end
			if (cmd.rewind) begin
				rd_q    <= '0;
				wr_q    <= '0;
				found_q <= 1'b0;
			end
			if (cmd.insert) begin
				full_q <= (used_q == CW'(TIMER_SLOTS));
				if (used_q != CW'(TIMER_SLOTS)) used_q <= used_q + CW'(1);
			end
			if (cmd.walk) begin
				rd_q <= rd_q + CW'(1);
				if (keep) begin
					if (!minv_q || new_rem < min_q) min_q <= new_rem;
					minv_q <= 1'b1;
				end else found_q <= 1'b1;
			end
			if (cmd.scan) begin
				rd_q <= rd_q + CW'(1);
				if (keep) wr_q <= wr_q + CW'(1);
				else found_q <= 1'b1;
			end
			if (cmd.finish) used_q <= wr_q;
		end
	end
endmodule

// ===== hw/rtl/mtet_checker.sv =====
// Port checker for the timer pool, bound to the top level.
// Depends on mtet_pkg and multi_timer_event_table_assert.svh.
`include "multi_timer_event_table_assert.svh"
module mtet_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input mtet_pkg::out_item_t out_data
);
	import mtet_pkg::*;
	`MTET_ASSERT(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "output changed while stalled")
	`MTET_ASSERT(a_busy, clk, arst_n, in_valid && in_ready |=> !in_ready, "accepted twice in a row")
	`MTET_ASSERT(a_kind, clk, arst_n, out_valid && out_data.result_kind == RK_EXPIRY |-> !out_data.last, "expiry marked last")
endmodule

bind multi_timer_event_table mtet_checker u_chk (.*, .out_data(out_data));

// ===== verif/multi_timer_event_table_test.sv =====
// Self-checking bench for the multi_timer_event_table timer pool.
// Depends on mtet_pkg and the multi_timer_event_table RTL.
module multi_timer_event_table_test;
	import mtet_pkg::*;

	localparam int SLOTS = TimerSlotsDefault;
	localparam int RANDOM_ITEMS = 160;
	localparam int IDLE_LIMIT = 3000;

	// Mirror of the timer pool: entry 0 is the newest timer.
	class timer_pool_scoreboard;
		int unsigned used;
		logic [7:0] pool_msg [SLOTS];
		logic [7:0] pool_kind [SLOTS];
		logic [7:0] pool_recv [SLOTS];
		logic [RemW-1:0] pool_left [SLOTS];
		logic [31:0] runtime;
		out_item_t expected_results[$];
		int errors;
		int results_seen;
		int expiries_seen;
		int fulls_seen;
		int nomatch_seen;

		function void clear();
			used = 0;
			runtime = '0;
			expected_results.delete();
			errors = 0;
			results_seen = 0;
			expiries_seen = 0;
			fulls_seen = 0;
			nomatch_seen = 0;
		endfunction

		function out_item_t blank(logic [1:0] kind, logic [1:0] st);
			out_item_t r;
			r = '0;
			r.result_kind = kind;
			r.status = st;
			return r;
		endfunction

		// Advance the mirror by one accepted command and queue its results.
		function void note_command(in_item_t it);
			out_item_t step_q[$];
			out_item_t r;
			logic [31:0] t;
			logic [31:0] best;
			int unsigned w;
			bit hit;
			case (cmd_t'(it.command))
				CMD_REQUEST: begin
					t = (it.delay_ms > 32'd20) ? it.delay_ms / 32'd10 + 32'd1 : 32'd2;
					if (used >= SLOTS) begin
						step_q.push_back(blank(RK_STATUS, ST_FULL));
					end else begin
						for (int i = used; i > 0; i--) begin
							pool_msg[i] = pool_msg[i-1];
							pool_kind[i] = pool_kind[i-1];
							pool_recv[i] = pool_recv[i-1];
							pool_left[i] = pool_left[i-1];
						end
						pool_msg[0] = it.message_id;
						pool_kind[0] = it.event_kind;
						pool_recv[0] = it.receiver_id;
						pool_left[0] = t[RemW-1:0];
						used++;
						step_q.push_back(blank(RK_STATUS, ST_OK));
					end
				end
				CMD_CANCEL: begin
					hit = 0;
					for (int i = 0; i < used && !hit; i++) begin
						if (pool_recv[i] == it.receiver_id && pool_msg[i] == it.message_id) begin
							hit = 1;
							for (int j = i; j + 1 < used; j++) begin
								pool_msg[j] = pool_msg[j+1];
								pool_kind[j] = pool_kind[j+1];
								pool_recv[j] = pool_recv[j+1];
								pool_left[j] = pool_left[j+1];
							end
							used--;
						end
					end
					step_q.push_back(blank(RK_STATUS, hit ? ST_OK : ST_NOMATCH));
				end
				CMD_TICK: begin
					runtime += it.elapsed_ticks;
					w = 0;
					for (int i = 0; i < used; i++) begin
						if ({3'b0, pool_left[i]} <= it.elapsed_ticks) begin
							r = blank(RK_EXPIRY, ST_OK);
							r.out_receiver = pool_recv[i];
							r.out_kind = pool_kind[i];
							r.out_message = pool_msg[i];
							step_q.push_back(r);
						end else begin
							pool_left[w] = pool_left[i] - it.elapsed_ticks[RemW-1:0];
							pool_msg[w] = pool_msg[i];
							pool_kind[w] = pool_kind[i];
							pool_recv[w] = pool_recv[i];
							w++;
						end
					end
					used = w;
					step_q.push_back(blank(RK_TICK, ST_OK));
				end
				default: step_q.push_back(blank(RK_STATUS, ST_OK));
			endcase
			best = '0;
			for (int i = 0; i < used; i++)
				if (best == 0 || pool_left[i] < best) best = pool_left[i];
			foreach (step_q[k]) begin
				step_q[k].shortest_ms = 33'(best) * 33'd10;
				step_q[k].runtime_ticks = runtime;
				step_q[k].last = (k == step_q.size() - 1);
				expected_results.push_back(step_q[k]);
			end
		endfunction

		// Compare one accepted result against the oldest expectation.
		function void check_result(out_item_t got);
			out_item_t exp_r;
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %p", $realtime, got);
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			if (got.result_kind == RK_EXPIRY) expiries_seen++;
			if (got.status == ST_FULL) fulls_seen++;
			if (got.status == ST_NOMATCH) nomatch_seen++;
			if (got.result_kind !== exp_r.result_kind) report("result_kind", exp_r.result_kind, got.result_kind);
			if (got.status !== exp_r.status) report("status", exp_r.status, got.status);
			if (got.out_receiver !== exp_r.out_receiver)
				report("out_receiver", exp_r.out_receiver, got.out_receiver);
			if (got.out_kind !== exp_r.out_kind) report("out_kind", exp_r.out_kind, got.out_kind);
			if (got.out_message !== exp_r.out_message)
				report("out_message", exp_r.out_message, got.out_message);
			if (got.shortest_ms !== exp_r.shortest_ms)
				report("shortest_ms", exp_r.shortest_ms, got.shortest_ms);
			if (got.runtime_ticks !== exp_r.runtime_ticks)
				report("runtime_ticks", exp_r.runtime_ticks, got.runtime_ticks);
			if (got.last !== exp_r.last) report("last", exp_r.last, got.last);
		endfunction

		function void report(string field, logic [32:0] e, logic [32:0] a);
			$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, e, a);
			errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	timer_pool_scoreboard timer_sb;
	int idle_cycles;
	int sent;
	bit bursty;       // when clear, both sides run without random gaps
	bit hold_done;    // receiver long hold-off has happened

	multi_timer_event_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #2 clk = ~clk;

	// Watch both channels at the rising edge; feed the scoreboard and the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) timer_sb.note_command(in_data);
			if (out_valid && out_ready) timer_sb.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("%0t: watchdog, no transaction for %0d cycles", $realtime, idle_cycles);
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	function automatic int draw_gap();
		return bursty ? $urandom_range(0, 12) : 0;
	endfunction

	// Offer one transaction at a falling edge, hold it until accepted.
	task automatic send_command(in_item_t it);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	function automatic in_item_t make_cmd(cmd_t c, logic [7:0] msg, logic [7:0] kind,
			logic [7:0] recv, logic [31:0] delay, logic [31:0] ticks);
		in_item_t it;
		it.command = c;
		it.message_id = msg;
		it.event_kind = kind;
		it.receiver_id = recv;
		it.delay_ms = delay;
		it.elapsed_ticks = ticks;
		return it;
	endfunction

	// Random command: mostly requests and ticks with short delays, cancels
	// usually aimed at a live timer so that matches actually happen.
	function automatic in_item_t random_cmd();
		in_item_t it;
		int sel;
		int pick;
		it = make_cmd(CMD_REQUEST, 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
			$urandom);
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			it.command = CMD_REQUEST;
			pick = $urandom_range(0, 9);
			if (pick < 7) it.delay_ms = $urandom_range(0, 600);
			else if (pick < 9) it.delay_ms = $urandom_range(0, 25);
		end else if (sel < 57) begin
			it.command = CMD_CANCEL;
			if (timer_sb.used > 0 && $urandom_range(0, 9) < 7) begin
				pick = $urandom_range(0, timer_sb.used - 1);
				it.message_id = timer_sb.pool_msg[pick];
				it.receiver_id = timer_sb.pool_recv[pick];
			end
		end else if (sel < 95) begin
			it.command = CMD_TICK;
			pick = $urandom_range(0, 19);
			if (pick < 16) it.elapsed_ticks = $urandom_range(0, 40);
			else if (pick < 18) it.elapsed_ticks = 0;
		end else begin
			it.command = CMD_NONE;
		end
		return it;
	endfunction

	// Receiver: random ready gaps, plus one long hold-off to back the pool up.
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && sent >= 60) begin
				hold_done = 1;
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
			end
			gap = draw_gap();
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		timer_sb = new;
		timer_sb.clear();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		idle_cycles = 0;
		sent = 0;
		bursty = 1;
		hold_done = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed: delay edges, full pool, cancel hit and miss, tick extremes.
		send_command(make_cmd(CMD_REQUEST, 8'h00, 8'h00, 8'h80, 32'd0, 32'd0));
		send_command(make_cmd(CMD_REQUEST, 8'hff, 8'hff, 8'h7f, 32'd20, 32'hffff_ffff));
		send_command(make_cmd(CMD_REQUEST, 8'h12, 8'h34, 8'hff, 32'd21, 32'd0));
		send_command(make_cmd(CMD_REQUEST, 8'h55, 8'haa, 8'h00, 32'hffff_ffff, 32'd0));
		for (int i = 0; i < 5; i++)
			send_command(make_cmd(CMD_REQUEST, 8'(i), 8'(i + 1), 8'h01, 32'(100 * i), 32'd0));
		send_command(make_cmd(CMD_CANCEL, 8'h12, 8'h00, 8'hff, 32'd0, 32'd0));
		send_command(make_cmd(CMD_CANCEL, 8'h12, 8'h00, 8'hff, 32'd0, 32'd0));
		send_command(make_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 32'd0, 32'd0));
		send_command(make_cmd(CMD_NONE, 8'hff, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff));
		send_command(make_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 32'd0, 32'd2));
		send_command(make_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 32'd0, 32'd20));
		send_command(make_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 32'd0, 32'hffff_ffff));
		send_command(make_cmd(CMD_CANCEL, 8'h00, 8'h00, 8'h00, 32'd0, 32'd0));

		// Random part; alternate gap-free stretches with gappy ones.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 30 == 0) bursty = (n / 30) % 2 == 0;
			if (n == 100) begin
				// Pause the sender until the block has drained completely.
				in_valid = 1'b0;
				while (timer_sb.expected_results.size() != 0) @(negedge clk);
			end
			send_command(random_cmd());
		end
		in_valid = 1'b0;

		while (timer_sb.expected_results.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);

		$display("Sent %0d commands, checked %0d results: %0d expiries, %0d full, %0d no-match.",
			sent, timer_sb.results_seen, timer_sb.expiries_seen, timer_sb.fulls_seen,
			timer_sb.nomatch_seen);
		if (timer_sb.errors == 0 && timer_sb.expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mtet_pkg.sv
hw/rtl/mtet_ctrl.sv
hw/rtl/mtet_dp.sv
hw/rtl/multi_timer_event_table.sv
hw/rtl/mtet_checker.sv
verif/multi_timer_event_table_test.sv
